@@ rtl/ssps_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo status packet scanner package
// Shared state, status code and control/status bundle types.
// ----------------------------------------------------------------------------
package ssps_pkg;

   localparam logic [7:0] HDR_BYTE = 8'hFF;
   localparam int MIN_BATCH = 6;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_TIMEOUT   = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_code_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BEGIN,
      S_READ,
      S_EVAL,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store;
      logic start;
      logic read;
      logic next_idx;
      logic next_pos;
      logic clear_count;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic short_batch;
      logic reject;
      logic found;
      logic last_pos;
   } dp_sts_type;

endpackage

@@ rtl/ssps_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ssps_datapath.sv @@
// ----------------------------------------------------------------------------
// Servo status packet scanner datapath
// Byte store, fill count, scan offset and packet field checks.
// ----------------------------------------------------------------------------
module ssps_datapath
   import ssps_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output dp_sts_type   sts,
   input  logic [7:0]   req_rx_byte,
   input  logic [7:0]   req_servo_id
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = ((CW > 9) ? CW : 9) + 1;
   localparam int IW = 9;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [7:0]    id_ff, id_in;
   logic [7:0]    len_ff, len_in;
   logic          err_nz_ff, err_nz_in;
   logic [7:0]    total_ff, total_in;

   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [SW-1:0] addr_sum;
   logic [SW-1:0] pkt_end;
   logic [IW-1:0] chk_idx;

   ssps_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      wr_en    = cmd.store && (count_ff < CW'(DEPTH));
      addr_sum = SW'(pos_ff) + SW'(idx_ff);
      rd_addr  = addr_sum[AW-1:0];
      pkt_end  = SW'(pos_ff) + SW'(rd_data) + SW'(4);
      chk_idx  = IW'(len_ff) + IW'(3);

      sts.short_batch = count_ff < CW'(MIN_BATCH);
      sts.last_pos    = (SW'(pos_ff) + SW'(MIN_BATCH + 1)) > SW'(count_ff);
      sts.found       = 1'b0;
      sts.reject      = 1'b0;
      if (idx_ff < IW'(2)) begin
         sts.reject = rd_data != HDR_BYTE;
      end else if (idx_ff == IW'(2)) begin
         sts.reject = rd_data != id_ff;
      end else if (idx_ff == IW'(3)) begin
         sts.reject = (rd_data < 8'd2) || (pkt_end > SW'(count_ff));
      end else if (idx_ff == chk_idx) begin
         sts.found  = (rd_data == ~total_ff) && !err_nz_ff;
         sts.reject = !sts.found;
      end

      count_in  = count_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      err_nz_in = err_nz_ff;
      total_in  = total_ff;

      if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.clear_count) begin
         count_in = '0;
      end
      if (cmd.start) begin
         pos_in = '0;
         idx_in = '0;
         id_in  = req_servo_id;
      end
      if (cmd.next_pos) begin
         pos_in = pos_ff + CW'(1);
         idx_in = '0;
      end
      if (cmd.next_idx) begin
         idx_in   = idx_ff + IW'(1);
         // The checksum runs from the id byte through the last parameter.
         total_in = (idx_ff == IW'(2)) ? rd_data : total_ff + rd_data;
         if (idx_ff == IW'(3)) begin
            len_in = rd_data;
         end
         if (idx_ff == IW'(4)) begin
            err_nz_in = rd_data != 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      id_ff     <= id_in;
      len_ff    <= len_in;
      err_nz_ff <= err_nz_in;
      total_ff  <= total_in;
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("byte count exceeds store depth");

   a_found_no_err : assert property (@(posedge clock) disable iff (reset)
      sts.found |-> !err_nz_ff && !sts.reject)
      else $error("packet accepted with error byte set");

endmodule

@@ rtl/ssps_ctrl.sv @@
// ----------------------------------------------------------------------------
// Servo status packet scanner controller
// Request handshake, scan sequencing and the result register.
// ----------------------------------------------------------------------------
module ssps_ctrl
   import ssps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_byte_present,
   input  logic         req_batch_end,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_status,
   output ctrl_cmd_type cmd,
   input  dp_sts_type   sts
);

   state_type       state_ff, state_in;
   status_code_type result_ff, result_in;
   status_code_type status_ff, status_in;
   logic            rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in     = state_ff;
      result_in    = result_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store = req_byte_present;
               if (req_batch_end) begin
                  cmd.start = 1'b1;
                  state_in  = S_BEGIN;
               end
            end
         end
         S_BEGIN: begin
            if (sts.short_batch) begin
               result_in = ST_TIMEOUT;
               state_in  = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (sts.found) begin
               result_in = ST_FOUND;
               state_in  = S_DONE;
            end else if (sts.reject) begin
               if (sts.last_pos) begin
                  result_in = ST_NOT_FOUND;
                  state_in  = S_DONE;
               end else begin
                  cmd.next_pos = 1'b1;
                  state_in     = S_READ;
               end
            end else begin
               cmd.next_idx = 1'b1;
               state_in     = S_READ;
            end
         end
         S_DONE: begin
            // Wait for the result register to free up before posting.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               status_in       = result_ff;
               cmd.clear_count = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;

   a_end_starts_scan : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_batch_end) |=> state_ff == S_BEGIN)
      else $error("batch end did not start a scan");

   a_post_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response posted outside the done state");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(status_ff))
      else $error("pending response overwritten");

endmodule

@@ rtl/servo_status_packet_scanner.sv @@
// ----------------------------------------------------------------------------
// Servo status packet scanner
// Collects a batch of received bytes and searches it for a status packet.
// ----------------------------------------------------------------------------
// Each request carries at most one byte; bytes are stored one per cycle while
// the scanner is idle, and bytes beyond BUFFER_DEPTH are dropped. A request
// with batch_end set closes the batch after its own byte is stored, and
// starts the scan with the id in servo_id. The scan reads the byte store
// through its single read port: each byte is first addressed in the RAM,
// then checked. Every start offset that leaves room for a minimum-length
// packet is tried in turn, and a candidate packet reads at most length+4
// bytes. The response becomes valid in the same cycle that the scanner
// returns to idle and takes requests again. During the scan no request is
// accepted. Exactly one response, status found/timeout/not found, is produced
// per batch end; it is held in an output register until taken, and new bytes
// are accepted while it waits. A stalled response holds off the result of the
// next scan, and the requests behind it. Reset empties the batch and drops
// any pending response.
// ----------------------------------------------------------------------------
module servo_status_packet_scanner
   import ssps_pkg::*;
#(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_byte_present,
   input  logic       req_batch_end,
   input  logic [7:0] req_servo_id,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   ssps_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_present (req_byte_present),
      .req_batch_end    (req_batch_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .sts              (sts)
   );

   ssps_datapath #(
      .DEPTH (BUFFER_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_rx_byte  (req_rx_byte),
      .req_servo_id (req_servo_id)
   );

endmodule
